### sv/vvhw_pkg.sv
// ---------------------------------------------------------------------------
// vvhw_pkg
// Shared types and constants for the velocity-Verlet hard-wall step pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package vvhw_pkg;

  // field widths
  localparam int DT_W     = 24;
  localparam int BOX_W    = 31;
  localparam int FIELD_W  = 32;
  localparam int ENERGY_W = 63;
  localparam int SUM_W    = 64;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  // fixed-point shifts
  localparam int DRIFT_SHIFT = 24;
  localparam int KICK_SHIFT  = 25;
  localparam int HDSQ_SHIFT  = 25;
  localparam int HDSQ_W      = 2 * DT_W - HDSQ_SHIFT;

  // product and wide-sum widths
  localparam int PROD_W = DT_W + 1 + FIELD_W;
  localparam int WIDE_W = 36;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_Y    = 2'd2;

  // reset values of the registers
  localparam logic [DT_W-1:0]  TIME_STEP_RST = 24'd33554;
  localparam logic [BOX_W-1:0] WALL_X_RST    = 31'd655360;
  localparam logic [BOX_W-1:0] WALL_Y_RST    = 31'd655360;

  // operating modes
  localparam logic MODE_DRIFT = 1'b0;
  localparam logic MODE_KICK  = 1'b1;

  // one accepted input word
  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [FIELD_W-1:0] force_x;
    logic signed [FIELD_W-1:0] force_y;
    logic                      final_particle;
  } item_t;

  // products stage contents
  typedef struct packed {
    logic                      mode;
    logic                      final_particle;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [PROD_W-1:0]  dtv_x;
    logic signed [PROD_W-1:0]  dtv_y;
    logic signed [PROD_W-1:0]  hff_x;
    logic signed [PROD_W-1:0]  hff_y;
    logic signed [PROD_W-1:0]  dtf_x;
    logic signed [PROD_W-1:0]  dtf_y;
  } prod_t;

  // updated particle state
  typedef struct packed {
    logic                      mode;
    logic                      final_particle;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
  } upd_t;

  // one result word
  typedef struct packed {
    logic signed [FIELD_W-1:0] new_pos_x;
    logic signed [FIELD_W-1:0] new_pos_y;
    logic signed [FIELD_W-1:0] new_vel_x;
    logic signed [FIELD_W-1:0] new_vel_y;
    logic [ENERGY_W-1:0]       kinetic_energy;
    logic                      energy_valid;
  } res_t;

endpackage

`default_nettype wire

### sv/velocity_verlet_hard_wall_step_top.sv
// ---------------------------------------------------------------------------
// velocity_verlet_hard_wall_step_top
// 2D velocity-Verlet step with hard walls and kinetic energy sum, Q16.16.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle while the result channel is not stalled;
// input, product, update, square and result registers form a five-register
// pipeline with per-stage valid.
// Reset: synchronous, active low; clears pipeline valids and the energy sum,
// and loads the default timestep and box extents.
`default_nettype none

module velocity_verlet_hard_wall_step_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [vvhw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vvhw_pkg::CFG_W-1:0]         cfg_wr_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_mode,
  input  wire logic signed [vvhw_pkg::FIELD_W-1:0] in_pos_x,
  input  wire logic signed [vvhw_pkg::FIELD_W-1:0] in_pos_y,
  input  wire logic signed [vvhw_pkg::FIELD_W-1:0] in_vel_x,
  input  wire logic signed [vvhw_pkg::FIELD_W-1:0] in_vel_y,
  input  wire logic signed [vvhw_pkg::FIELD_W-1:0] in_force_x,
  input  wire logic signed [vvhw_pkg::FIELD_W-1:0] in_force_y,
  input  wire logic                               in_final_particle,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [vvhw_pkg::FIELD_W-1:0]     out_new_pos_x,
  output logic signed [vvhw_pkg::FIELD_W-1:0]     out_new_pos_y,
  output logic signed [vvhw_pkg::FIELD_W-1:0]     out_new_vel_x,
  output logic signed [vvhw_pkg::FIELD_W-1:0]     out_new_vel_y,
  output logic [vvhw_pkg::ENERGY_W-1:0]           out_kinetic_energy,
  output logic                                    out_energy_valid
);
  import vvhw_pkg::*;

  // configuration registers
  logic [DT_W-1:0]     time_step_r;
  logic [BOX_W-1:0]    wall_x_r;
  logic [BOX_W-1:0]    wall_y_r;
  logic [2*DT_W-1:0]   dt_sq;
  logic [HDSQ_W-1:0]   half_dt_sq_r;

  // input register
  logic                in_valid_r;
  item_t               item_r;
  item_t               item_nxt;
  logic                in_ready;

  // stage links
  logic                prod_ready;
  logic                prod_valid;
  prod_t               prod;
  logic                upd_ready;
  logic                upd_valid;
  upd_t                upd;
  logic                eng_ready;
  res_t                res;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      wall_x_r    <= WALL_X_RST;
      wall_y_r    <= WALL_Y_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIME_STEP: time_step_r <= cfg_wr_data[DT_W-1:0];
        REG_WALL_X:    wall_x_r    <= cfg_wr_data[BOX_W-1:0];
        REG_WALL_Y:    wall_y_r    <= cfg_wr_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // dt*dt/2 is registered and follows the timestep in the next cycle
  assign dt_sq = {{DT_W{1'b0}}, time_step_r} * {{DT_W{1'b0}}, time_step_r};

  always_ff @(posedge clk) begin
    half_dt_sq_r <= dt_sq[2*DT_W-1:HDSQ_SHIFT];
  end

  // input register
  always_comb begin
    item_nxt.mode           = in_mode;
    item_nxt.pos_x          = in_pos_x;
    item_nxt.pos_y          = in_pos_y;
    item_nxt.vel_x          = in_vel_x;
    item_nxt.vel_y          = in_vel_y;
    item_nxt.force_x        = in_force_x;
    item_nxt.force_y        = in_force_y;
    item_nxt.final_particle = in_final_particle;
  end

  assign in_ready = !in_valid_r || prod_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  vvhw_product u_product (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid_r),
    .up_item    (item_r),
    .up_ready   (prod_ready),
    .time_step  (time_step_r),
    .half_dt_sq (half_dt_sq_r),
    .dn_valid   (prod_valid),
    .dn_prod    (prod),
    .dn_ready   (upd_ready)
  );

  vvhw_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (prod_valid),
    .up_prod    (prod),
    .up_ready   (upd_ready),
    .wall_x     (wall_x_r),
    .wall_y     (wall_y_r),
    .dn_valid   (upd_valid),
    .dn_upd     (upd),
    .dn_ready   (eng_ready)
  );

  vvhw_energy u_energy (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (upd_valid),
    .up_upd   (upd),
    .up_ready (eng_ready),
    .dn_valid (out_valid),
    .dn_res   (res),
    .dn_ready (!out_stall)
  );

  // result fields
  assign out_new_pos_x      = res.new_pos_x;
  assign out_new_pos_y      = res.new_pos_y;
  assign out_new_vel_x      = res.new_vel_x;
  assign out_new_vel_y      = res.new_vel_y;
  assign out_kinetic_energy = res.kinetic_energy;
  assign out_energy_valid   = res.energy_valid;

endmodule

`default_nettype wire

### sv/vvhw_product.sv
// ---------------------------------------------------------------------------
// vvhw_product
// Product stage: forms dt*v, (dt*dt/2)*f and dt*f for both axes.
// ---------------------------------------------------------------------------
`default_nettype none

module vvhw_product (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  input  wire vvhw_pkg::item_t             up_item,
  output logic                             up_ready,
  input  wire logic [vvhw_pkg::DT_W-1:0]   time_step,
  input  wire logic [vvhw_pkg::HDSQ_W-1:0] half_dt_sq,
  output logic                             dn_valid,
  output vvhw_pkg::prod_t                  dn_prod,
  input  wire logic                        dn_ready
);
  import vvhw_pkg::*;

  logic                     valid_r;
  prod_t                    prod_r;
  prod_t                    prod_nxt;
  logic signed [DT_W:0]     dt_s;
  logic signed [HDSQ_W:0]   hdsq_s;

  assign dt_s     = $signed({1'b0, time_step});
  assign hdsq_s   = $signed({1'b0, half_dt_sq});
  assign up_ready = !valid_r || dn_ready;

  // independent multiplies, one per term
  always_comb begin
    prod_nxt.mode           = up_item.mode;
    prod_nxt.final_particle = up_item.final_particle;
    prod_nxt.pos_x          = up_item.pos_x;
    prod_nxt.pos_y          = up_item.pos_y;
    prod_nxt.vel_x          = up_item.vel_x;
    prod_nxt.vel_y          = up_item.vel_y;
    prod_nxt.dtv_x          = PROD_W'(dt_s * up_item.vel_x);
    prod_nxt.dtv_y          = PROD_W'(dt_s * up_item.vel_y);
    prod_nxt.hff_x          = PROD_W'(hdsq_s * up_item.force_x);
    prod_nxt.hff_y          = PROD_W'(hdsq_s * up_item.force_y);
    prod_nxt.dtf_x          = PROD_W'(dt_s * up_item.force_x);
    prod_nxt.dtf_y          = PROD_W'(dt_s * up_item.force_y);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_prod  = prod_r;

endmodule

`default_nettype wire

### sv/vvhw_update.sv
// ---------------------------------------------------------------------------
// vvhw_update
// Update stage: drift with half kick and wall reflection, or second half kick.
// ---------------------------------------------------------------------------
`default_nettype none

module vvhw_update (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       up_valid,
  input  wire vvhw_pkg::prod_t            up_prod,
  output logic                            up_ready,
  input  wire logic [vvhw_pkg::BOX_W-1:0] wall_x,
  input  wire logic [vvhw_pkg::BOX_W-1:0] wall_y,
  output logic                            dn_valid,
  output vvhw_pkg::upd_t                  dn_upd,
  input  wire logic                       dn_ready
);
  import vvhw_pkg::*;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos;
    logic signed [FIELD_W-1:0] vel;
  } axis_t;

  logic  valid_r;
  upd_t  upd_r;
  upd_t  upd_nxt;
  axis_t drift_x;
  axis_t drift_y;

  // clamp a wide value to the 32-bit signed range
  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] max_w;
    logic signed [WIDE_W-1:0] min_w;
    max_w = WIDE_W'({1'b0, {(FIELD_W-1){1'b1}}});
    min_w = -max_w - WIDE_W'(1);
    if (x > max_w) begin
      sat32 = {1'b0, {(FIELD_W-1){1'b1}}};
    end else if (x < min_w) begin
      sat32 = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      sat32 = x[FIELD_W-1:0];
    end
  endfunction

  // kicked velocity, before saturation
  function automatic logic signed [WIDE_W-1:0] kick_wide(
    input logic signed [FIELD_W-1:0] v,
    input logic signed [PROD_W-1:0]  dtf
  );
    kick_wide = WIDE_W'(v) + WIDE_W'(dtf >>> KICK_SHIFT);
  endfunction

  // drift, half kick and one wall reflection for one axis
  function automatic axis_t drift_axis(
    input logic signed [FIELD_W-1:0] p,
    input logic signed [FIELD_W-1:0] v,
    input logic signed [PROD_W-1:0]  dtv,
    input logic signed [PROD_W-1:0]  hff,
    input logic signed [PROD_W-1:0]  dtf,
    input logic [BOX_W-1:0]          extent
  );
    logic signed [WIDE_W-1:0] wide_p;
    logic signed [WIDE_W-1:0] wide_v;
    logic signed [WIDE_W-1:0] ext;
    axis_t                    res;
    wide_p = WIDE_W'(p) + WIDE_W'(dtv >>> DRIFT_SHIFT) + WIDE_W'(hff >>> DRIFT_SHIFT);
    wide_v = kick_wide(v, dtf);
    ext    = $signed({{(WIDE_W-BOX_W){1'b0}}, extent});
    if (wide_p > ext) begin
      wide_p = (ext <<< 1) - wide_p;
      wide_v = -wide_v;
    end else if (wide_p < 0) begin
      wide_p = -wide_p;
      wide_v = -wide_v;
    end
    res.pos = sat32(wide_p);
    res.vel = sat32(wide_v);
    drift_axis = res;
  endfunction

  assign drift_x  = drift_axis(up_prod.pos_x, up_prod.vel_x, up_prod.dtv_x,
                               up_prod.hff_x, up_prod.dtf_x, wall_x);
  assign drift_y  = drift_axis(up_prod.pos_y, up_prod.vel_y, up_prod.dtv_y,
                               up_prod.hff_y, up_prod.dtf_y, wall_y);
  assign up_ready = !valid_r || dn_ready;

  // mode select
  always_comb begin
    upd_nxt.mode           = up_prod.mode;
    upd_nxt.final_particle = up_prod.final_particle;
    if (up_prod.mode == MODE_KICK) begin
      upd_nxt.pos_x = up_prod.pos_x;
      upd_nxt.pos_y = up_prod.pos_y;
      upd_nxt.vel_x = sat32(kick_wide(up_prod.vel_x, up_prod.dtf_x));
      upd_nxt.vel_y = sat32(kick_wide(up_prod.vel_y, up_prod.dtf_y));
    end else begin
      upd_nxt.pos_x = drift_x.pos;
      upd_nxt.pos_y = drift_y.pos;
      upd_nxt.vel_x = drift_x.vel;
      upd_nxt.vel_y = drift_y.vel;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      upd_r <= upd_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_upd   = upd_r;

endmodule

`default_nettype wire

### sv/vvhw_energy.sv
// ---------------------------------------------------------------------------
// vvhw_energy
// Squares the kicked speeds, keeps the saturating running sum and drives the
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module vvhw_energy (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  input  wire vvhw_pkg::upd_t  up_upd,
  output logic                 up_ready,
  output logic                 dn_valid,
  output vvhw_pkg::res_t       dn_res,
  input  wire logic            dn_ready
);
  import vvhw_pkg::*;

  // square stage
  logic               sq_valid_r;
  upd_t               sq_upd_r;
  logic [SUM_W-1:0]   sq_sum_r;
  logic               sq_ready;
  logic [FIELD_W-1:0] mag_x;
  logic [FIELD_W-1:0] mag_y;
  logic [SUM_W-1:0]   sq_x;
  logic [SUM_W-1:0]   sq_y;
  logic [SUM_W-1:0]   sq_sum_nxt;

  // result stage
  logic               res_valid_r;
  res_t               res_r;
  res_t               res_nxt;
  logic [SUM_W-1:0]   speed_sum_r;
  logic [SUM_W-1:0]   speed_sum_nxt;
  logic [SUM_W:0]     acc_wide;
  logic [SUM_W-1:0]   acc_sat;
  logic               res_ready;
  logic               res_load;

  // magnitudes and squares
  assign mag_x = up_upd.vel_x[FIELD_W-1] ? FIELD_W'(-up_upd.vel_x) : FIELD_W'(up_upd.vel_x);
  assign mag_y = up_upd.vel_y[FIELD_W-1] ? FIELD_W'(-up_upd.vel_y) : FIELD_W'(up_upd.vel_y);
  assign sq_x  = {{(SUM_W-FIELD_W){1'b0}}, mag_x} * {{(SUM_W-FIELD_W){1'b0}}, mag_x};
  assign sq_y  = {{(SUM_W-FIELD_W){1'b0}}, mag_y} * {{(SUM_W-FIELD_W){1'b0}}, mag_y};
  // each square is at most 2^62, so the pair fits
  assign sq_sum_nxt = (up_upd.mode == MODE_KICK) ? (sq_x + sq_y) : '0;

  assign up_ready = !sq_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (up_ready) begin
      sq_valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      sq_upd_r <= up_upd;
      sq_sum_r <= sq_sum_nxt;
    end
  end

  assign sq_ready = sq_valid_r;

  // saturating accumulate
  assign acc_wide = {1'b0, speed_sum_r} + {1'b0, sq_sum_r};
  assign acc_sat  = acc_wide[SUM_W] ? {SUM_W{1'b1}} : acc_wide[SUM_W-1:0];

  always_comb begin
    res_nxt.new_pos_x      = sq_upd_r.pos_x;
    res_nxt.new_pos_y      = sq_upd_r.pos_y;
    res_nxt.new_vel_x      = sq_upd_r.vel_x;
    res_nxt.new_vel_y      = sq_upd_r.vel_y;
    res_nxt.kinetic_energy = '0;
    res_nxt.energy_valid   = 1'b0;
    speed_sum_nxt          = speed_sum_r;
    if (sq_upd_r.mode == MODE_KICK) begin
      if (sq_upd_r.final_particle) begin
        res_nxt.kinetic_energy = acc_sat[SUM_W-1:1];
        res_nxt.energy_valid   = 1'b1;
        speed_sum_nxt          = '0;
      end else begin
        speed_sum_nxt = acc_sat;
      end
    end
  end

  assign res_ready = !res_valid_r || dn_ready;
  assign res_load  = res_ready && sq_ready;

  // result register and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      speed_sum_r <= '0;
    end else begin
      if (res_ready) begin
        res_valid_r <= sq_valid_r;
      end
      if (res_load) begin
        speed_sum_r <= speed_sum_nxt;
      end
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = res_valid_r;
  assign dn_res   = res_r;

endmodule

`default_nettype wire
